@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the histogram block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define HB_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define HB_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/hb_pkg.sv @@
// Types, constants and codes shared by the histogram builder modules.
package hb_pkg;

    localparam int MAX_SAMPLES = 1024;
    localparam int NBINS       = 64;

    localparam int ADDR_W   = $clog2(MAX_SAMPLES);
    localparam int TOT_W    = $clog2(MAX_SAMPLES + 1);
    localparam int BIN_AW   = $clog2(NBINS);
    localparam int CNT_W    = 7;

    localparam int DIV_W      = 40;
    localparam int DEN_W      = 32;
    localparam int DIV_STEP_W = $clog2(DIV_W);

    localparam int SQ_W      = (TOT_W + 33) / 2;
    localparam int SQ_IN_W   = 2 * SQ_W;
    localparam int SQ_STEP_W = $clog2(SQ_W);

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_BOUNDS,
        STAT_INDEX,
        STAT_OVERFLOW
    } status_t;

    typedef enum logic [2:0] {
        REG_USE_LOW,
        REG_LOW_BOUND,
        REG_USE_HIGH,
        REG_HIGH_BOUND,
        REG_NORMALIZE,
        REG_WIDTH_MODE,
        REG_BIN_COUNT,
        REG_BIN_WIDTH
    } reg_index_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_CHECK,
        ST_CNT_DIV,
        ST_RD,
        ST_SAMP,
        ST_IDX_DIV,
        ST_BIN,
        ST_INC,
        ST_OUT_RD,
        ST_OUT_C,
        ST_CTR_DIV,
        ST_CTR,
        ST_SQ_WAIT,
        ST_SH_DIV,
        ST_SP_DIV,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/hb_div.sv @@
// Restoring divider, one quotient bit per cycle.
module hb_div import hb_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [DIV_STEP_W-1:0] LAST_STEP = DIV_STEP_W'(DIV_W - 1);

    logic                  run_reg, run_next;
    logic                  done_reg, done_next;
    logic [DIV_STEP_W-1:0] step_reg, step_next;
    logic [DIV_W-1:0]      num_reg, num_next;
    logic [DEN_W-1:0]      den_reg, den_next;
    logic [DEN_W-1:0]      rem_reg, rem_next;

    logic [DEN_W:0] trial;
    logic [DEN_W:0] diff;
    logic           ge;

    always_comb
    begin
        trial     = {rem_reg, num_reg[DIV_W-1]};
        diff      = trial - {1'b0, den_reg};
        ge        = trial >= {1'b0, den_reg};
        run_next  = run_reg;
        done_next = 1'b0;
        step_next = step_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        if (run_reg)
        begin
            rem_next  = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            num_next  = {num_reg[DIV_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (req.start)
        begin
            num_next  = req.dividend;
            den_next  = req.divisor;
            rem_next  = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        den_reg <= den_next;
        rem_reg <= rem_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = num_reg;

endmodule

@@ rtl/hb_sqrt.sv @@
// Digit-by-digit square root of a count shifted up by 32 bits.
module hb_sqrt import hb_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [TOT_W-1:0] value,
    output logic             idle,
    output logic [SQ_W-1:0]  root
);

    localparam logic [SQ_STEP_W-1:0] LAST_STEP = SQ_STEP_W'(SQ_W - 1);

    logic                 run_reg, run_next;
    logic [SQ_STEP_W-1:0] step_reg, step_next;
    logic [SQ_IN_W-1:0]   op_reg, op_next;
    logic [SQ_W:0]        rem_reg, rem_next;
    logic [SQ_W-1:0]      root_reg, root_next;

    logic [SQ_W+2:0] rem_sh;
    logic [SQ_W+2:0] trial;
    logic [SQ_W+2:0] diff;
    logic            ge;

    always_comb
    begin
        rem_sh    = {rem_reg, op_reg[SQ_IN_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        diff      = rem_sh - trial;
        ge        = rem_sh >= trial;
        run_next  = run_reg;
        step_next = step_reg;
        op_next   = op_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (run_reg)
        begin
            rem_next  = ge ? diff[SQ_W:0] : rem_sh[SQ_W:0];
            root_next = {root_reg[SQ_W-2:0], ge};
            op_next   = {op_reg[SQ_IN_W-3:0], 2'b00};
            step_next = step_reg + 1'b1;
            if (step_reg == LAST_STEP)
            begin
                run_next = 1'b0;
            end
        end
        else if (start)
        begin
            op_next   = SQ_IN_W'({value, 32'h0});
            rem_next  = '0;
            root_next = '0;
            step_next = '0;
            run_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign idle = !run_reg;
    assign root = root_reg;

endmodule

@@ rtl/histogram_builder.sv @@
// Histogram builder top level: sample store, binning sequencer and result output.
// Loading: one sample per cycle, busy stays low until the sample marked last is taken.
// Pass: a check step (a division in width mode); per stored sample a read, a range test and,
// if kept, an index division (none for a zero range) and a counter increment; then output.
// Results appear one per bin on strobe, in bin order; an error gives a single status result.
// Reset clears control state and loads register defaults; the sample store is not cleared.
module histogram_builder import hb_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] sample,
    input  logic               last_sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output logic               strobe,
    output logic [5:0]         bin_index,
    output logic signed [31:0] bin_center,
    output logic [10:0]        raw_count,
    output logic [26:0]        share,
    output logic [21:0]        spread,
    output logic [1:0]         status,
    output logic               last_bin
);

    // Configuration registers.
    logic               use_low_reg;
    logic signed [31:0] low_bound_reg;
    logic               use_high_reg;
    logic signed [31:0] high_bound_reg;
    logic               normalize_reg;
    logic               width_mode_reg;
    logic [6:0]         bin_count_reg;
    logic [30:0]        bin_width_reg;

    // Sequencer and data set state.
    state_t             state_reg, state_next;
    logic [TOT_W-1:0]   set_total_reg, set_total_next;
    logic               ovf_reg, ovf_next;
    logic signed [31:0] min_reg, min_next;
    logic signed [31:0] max_reg, max_next;
    logic signed [31:0] lo_reg, lo_next;
    logic signed [31:0] hi_reg, hi_next;
    logic [31:0]        range_reg, range_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [TOT_W-1:0]   ptr_reg, ptr_next;
    logic [TOT_W-1:0]   in_total_reg, in_total_next;
    logic [BIN_AW-1:0]  idx_reg, idx_next;
    logic [BIN_AW-1:0]  bin_reg, bin_next;
    logic [TOT_W-1:0]   cval_reg, cval_next;
    logic [DIV_W-1:0]   off_reg, off_next;
    logic [31:0]        ctr_reg, ctr_next;
    logic [26:0]        sh_reg, sh_next;
    logic [21:0]        sp_reg, sp_next;

    // Result registers.
    logic               strobe_reg, strobe_next;
    logic [5:0]         o_index_reg, o_index_next;
    logic [31:0]        o_center_reg, o_center_next;
    logic [10:0]        o_count_reg, o_count_next;
    logic [26:0]        o_share_reg, o_share_next;
    logic [21:0]        o_spread_reg, o_spread_next;
    status_t            o_status_reg, o_status_next;
    logic               o_last_reg, o_last_next;

    // Sample store.
    logic [31:0]        store_mem [MAX_SAMPLES];
    logic [31:0]        store_q_reg;
    logic               store_we;
    logic [ADDR_W-1:0]  store_ra;

    // Bin counters with per-entry valid bits.
    logic [TOT_W-1:0]   bin_mem [NBINS];
    logic [NBINS-1:0]   bin_valid_reg;
    logic [TOT_W-1:0]   bin_q_reg;
    logic               bin_qv_reg;
    logic               bin_we;
    logic               clear_valid;
    logic [BIN_AW-1:0]  bin_ra;
    logic [TOT_W-1:0]   bin_wd;

    // Shared units.
    div_req_t           div_req;
    div_rsp_t           div_rsp;
    logic               sq_start;
    logic [TOT_W-1:0]   sq_value;
    logic               sq_idle;
    logic [SQ_W-1:0]    sq_root;

    // Datapath terms.
    logic signed [31:0] lo_c, hi_c;
    logic               bad_c;
    logic [32:0]        range_c;
    logic signed [31:0] x_c;
    logic               in_rng_c;
    logic [32:0]        d_full_c;
    logic [31:0]        d_c;
    logic [38:0]        prod_idx_c;
    logic [38:0]        prod_ctr_c;
    logic [DIV_W-1:0]   prod_w_c;
    logic signed [40:0] ctr_sum_c;
    logic [TOT_W-1:0]   ptr_inc_c;
    logic               samples_done_c;
    logic [TOT_W-1:0]   cur_c;
    logic [DIV_W-1:0]   sh_c;
    logic [DIV_W-1:0]   half_c;
    logic               norm_c;

    function automatic logic [26:0] sat_share(input logic [DIV_W-1:0] v);
        sat_share = (v > DIV_W'(27'h7FFFFFF)) ? 27'h7FFFFFF : v[26:0];
    endfunction

    function automatic logic [21:0] sat_spread(input logic [DIV_W-1:0] v);
        sat_spread = (v > DIV_W'(22'h3FFFFF)) ? 22'h3FFFFF : v[21:0];
    endfunction

    hb_div u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    hb_sqrt u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .value (sq_value),
        .idle  (sq_idle),
        .root  (sq_root)
    );

    // Take configuration writes only while no data set is being binned.
    assign cfg_ready = (state_reg == ST_LOAD);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_low_reg    <= 1'b0;
            low_bound_reg  <= '0;
            use_high_reg   <= 1'b0;
            high_bound_reg <= '0;
            normalize_reg  <= 1'b1;
            width_mode_reg <= 1'b0;
            bin_count_reg  <= 7'd64;
            bin_width_reg  <= 31'd65536;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_USE_LOW:    use_low_reg    <= cfg_data[0];
                REG_LOW_BOUND:  low_bound_reg  <= cfg_data;
                REG_USE_HIGH:   use_high_reg   <= cfg_data[0];
                REG_HIGH_BOUND: high_bound_reg <= cfg_data;
                REG_NORMALIZE:  normalize_reg  <= cfg_data[0];
                REG_WIDTH_MODE: width_mode_reg <= cfg_data[0];
                REG_BIN_COUNT:  bin_count_reg  <= cfg_data[6:0];
                REG_BIN_WIDTH:  bin_width_reg  <= cfg_data[30:0];
                default:        ;
            endcase
        end
    end

    // Datapath terms shared by several states.
    always_comb
    begin
        lo_c      = use_low_reg ? low_bound_reg : min_reg;
        hi_c      = use_high_reg ? high_bound_reg : max_reg;
        bad_c     = (use_low_reg && use_high_reg && (low_bound_reg >= high_bound_reg))
                    || (lo_c > hi_c) || (width_mode_reg && (bin_width_reg == '0));
        range_c   = {hi_c[31], hi_c} - {lo_c[31], lo_c};
        x_c       = store_q_reg;
        in_rng_c  = (x_c >= lo_reg) && (x_c <= hi_reg);
        d_full_c  = {x_c[31], x_c} - {lo_reg[31], lo_reg};
        d_c       = d_full_c[31:0];
        prod_idx_c = 39'(d_c) * 39'(cnt_reg);
        prod_ctr_c = 39'({bin_reg, 1'b1}) * 39'(range_reg);
        prod_w_c   = DIV_W'(bin_reg) * DIV_W'(bin_width_reg)
                     + DIV_W'(bin_width_reg >> 1);
        ctr_sum_c  = 41'(lo_reg) + $signed({1'b0, off_reg});
        ptr_inc_c  = ptr_reg + 1'b1;
        samples_done_c = (ptr_inc_c == set_total_reg);
        cur_c      = bin_qv_reg ? bin_q_reg : '0;
        sh_c       = DIV_W'({cval_reg, 16'h0});
        half_c     = DIV_W'(in_total_reg >> 1);
        norm_c     = normalize_reg && (cnt_reg > 7'd1) && (in_total_reg != '0);
    end

    // Sequencer: next state, datapath registers and unit requests.
    always_comb
    begin
        state_next     = state_reg;
        set_total_next = set_total_reg;
        ovf_next       = ovf_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        range_next     = range_reg;
        cnt_next       = cnt_reg;
        ptr_next       = ptr_reg;
        in_total_next  = in_total_reg;
        idx_next       = idx_reg;
        bin_next       = bin_reg;
        cval_next      = cval_reg;
        off_next       = off_reg;
        ctr_next       = ctr_reg;
        sh_next        = sh_reg;
        sp_next        = sp_reg;

        strobe_next    = 1'b0;
        o_index_next   = o_index_reg;
        o_center_next  = o_center_reg;
        o_count_next   = o_count_reg;
        o_share_next   = o_share_reg;
        o_spread_next  = o_spread_reg;
        o_status_next  = o_status_reg;
        o_last_next    = o_last_reg;

        store_we       = 1'b0;
        store_ra       = ptr_reg[ADDR_W-1:0];
        bin_we         = 1'b0;
        bin_ra         = bin_reg;
        bin_wd         = cur_c + 1'b1;
        clear_valid    = 1'b0;
        div_req        = '0;
        sq_start       = 1'b0;
        sq_value       = cur_c;

        case (state_reg)
            ST_LOAD:
            begin
                if (start)
                begin
                    if (!ovf_reg)
                    begin
                        if (set_total_reg < TOT_W'(MAX_SAMPLES))
                        begin
                            store_we = 1'b1;
                            if (set_total_reg == '0)
                            begin
                                min_next = sample;
                                max_next = sample;
                            end
                            else
                            begin
                                if (sample < min_reg) min_next = sample;
                                if (sample > max_reg) max_next = sample;
                            end
                            set_total_next = set_total_reg + 1'b1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                    if (last_sample)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end

            ST_CHECK:
            begin
                lo_next       = lo_c;
                hi_next       = hi_c;
                range_next    = range_c[31:0];
                ptr_next      = '0;
                in_total_next = '0;
                if (ovf_reg || bad_c)
                begin
                    strobe_next    = 1'b1;
                    o_index_next   = '0;
                    o_center_next  = '0;
                    o_count_next   = '0;
                    o_share_next   = '0;
                    o_spread_next  = '0;
                    o_status_next  = ovf_reg ? STAT_OVERFLOW : STAT_BOUNDS;
                    o_last_next    = 1'b1;
                    set_total_next = '0;
                    ovf_next       = 1'b0;
                    clear_valid    = 1'b1;
                    state_next     = ST_LOAD;
                end
                else if (width_mode_reg)
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(range_c[31:0]);
                    div_req.divisor  = DEN_W'(bin_width_reg);
                    state_next       = ST_CNT_DIV;
                end
                else
                begin
                    if (bin_count_reg == '0)
                        cnt_next = 7'd1;
                    else if (bin_count_reg > CNT_W'(NBINS))
                        cnt_next = CNT_W'(NBINS);
                    else
                        cnt_next = bin_count_reg;
                    state_next = ST_RD;
                end
            end

            ST_CNT_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(NBINS))
                    begin
                        strobe_next    = 1'b1;
                        o_index_next   = '0;
                        o_center_next  = '0;
                        o_count_next   = '0;
                        o_share_next   = '0;
                        o_spread_next  = '0;
                        o_status_next  = STAT_INDEX;
                        o_last_next    = 1'b1;
                        set_total_next = '0;
                        ovf_next       = 1'b0;
                        clear_valid    = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next   = (div_rsp.quotient == '0) ? 7'd1
                                     : CNT_W'(div_rsp.quotient);
                        state_next = ST_RD;
                    end
                end
            end

            ST_RD:
            begin
                state_next = ST_SAMP;
            end

            ST_SAMP:
            begin
                if (!in_rng_c)
                begin
                    // Drop the sample and advance.
                    ptr_next = ptr_inc_c;
                    if (samples_done_c)
                    begin
                        bin_next   = '0;
                        state_next = ST_OUT_RD;
                    end
                    else
                    begin
                        state_next = ST_RD;
                    end
                end
                else if (range_reg == '0)
                begin
                    idx_next   = '0;
                    state_next = ST_BIN;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = width_mode_reg ? DIV_W'(d_c) : DIV_W'(prod_idx_c);
                    div_req.divisor  = width_mode_reg ? DEN_W'(bin_width_reg) : range_reg;
                    state_next       = ST_IDX_DIV;
                end
            end

            ST_IDX_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (div_rsp.quotient > DIV_W'(cnt_reg))
                    begin
                        strobe_next    = 1'b1;
                        o_index_next   = '0;
                        o_center_next  = '0;
                        o_count_next   = '0;
                        o_share_next   = '0;
                        o_spread_next  = '0;
                        o_status_next  = STAT_INDEX;
                        o_last_next    = 1'b1;
                        set_total_next = '0;
                        ovf_next       = 1'b0;
                        clear_valid    = 1'b1;
                        state_next     = ST_LOAD;
                    end
                    else
                    begin
                        // Pull an index at the top edge back into the last bin.
                        if (div_rsp.quotient == DIV_W'(cnt_reg))
                            idx_next = BIN_AW'(cnt_reg - 1'b1);
                        else
                            idx_next = BIN_AW'(div_rsp.quotient);
                        state_next = ST_BIN;
                    end
                end
            end

            ST_BIN:
            begin
                bin_ra     = idx_reg;
                state_next = ST_INC;
            end

            ST_INC:
            begin
                bin_we        = 1'b1;
                in_total_next = in_total_reg + 1'b1;
                ptr_next      = ptr_inc_c;
                if (samples_done_c)
                begin
                    bin_next   = '0;
                    state_next = ST_OUT_RD;
                end
                else
                begin
                    state_next = ST_RD;
                end
            end

            ST_OUT_RD:
            begin
                state_next = ST_OUT_C;
            end

            ST_OUT_C:
            begin
                cval_next = cur_c;
                sq_start  = 1'b1;
                if (width_mode_reg)
                begin
                    off_next   = prod_w_c;
                    state_next = ST_CTR;
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(prod_ctr_c);
                    div_req.divisor  = DEN_W'({cnt_reg, 1'b0});
                    state_next       = ST_CTR_DIV;
                end
            end

            ST_CTR_DIV:
            begin
                if (div_rsp.done)
                begin
                    off_next   = div_rsp.quotient;
                    state_next = ST_CTR;
                end
            end

            ST_CTR:
            begin
                ctr_next   = (ctr_sum_c > 41'sh7FFFFFFF) ? 32'h7FFFFFFF : ctr_sum_c[31:0];
                state_next = ST_SQ_WAIT;
            end

            ST_SQ_WAIT:
            begin
                if (sq_idle)
                begin
                    if (norm_c)
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = sh_c + half_c;
                        div_req.divisor  = DEN_W'(in_total_reg);
                        state_next       = ST_SH_DIV;
                    end
                    else
                    begin
                        sh_next    = sat_share(sh_c);
                        sp_next    = sat_spread(DIV_W'(sq_root));
                        state_next = ST_EMIT;
                    end
                end
            end

            ST_SH_DIV:
            begin
                if (div_rsp.done)
                begin
                    sh_next          = sat_share(div_rsp.quotient);
                    div_req.start    = 1'b1;
                    div_req.dividend = DIV_W'(sq_root) + half_c;
                    div_req.divisor  = DEN_W'(in_total_reg);
                    state_next       = ST_SP_DIV;
                end
            end

            ST_SP_DIV:
            begin
                if (div_rsp.done)
                begin
                    sp_next    = sat_spread(div_rsp.quotient);
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                strobe_next   = 1'b1;
                o_index_next  = 6'(bin_reg);
                o_center_next = ctr_reg;
                o_count_next  = (32'(cval_reg) > 32'd2047) ? 11'h7FF : 11'(cval_reg);
                o_share_next  = sh_reg;
                o_spread_next = sp_reg;
                o_status_next = STAT_OK;
                o_last_next   = (CNT_W'(bin_reg) + 1'b1) == cnt_reg;
                if (o_last_next)
                begin
                    set_total_next = '0;
                    ovf_next       = 1'b0;
                    clear_valid    = 1'b1;
                    state_next     = ST_LOAD;
                end
                else
                begin
                    bin_next   = bin_reg + 1'b1;
                    state_next = ST_OUT_RD;
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            set_total_reg <= '0;
            ovf_reg       <= 1'b0;
            min_reg       <= '0;
            max_reg       <= '0;
            strobe_reg    <= 1'b0;
            bin_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            set_total_reg <= set_total_next;
            ovf_reg       <= ovf_next;
            min_reg       <= min_next;
            max_reg       <= max_next;
            strobe_reg    <= strobe_next;
            if (clear_valid)
                bin_valid_reg <= '0;
            else if (bin_we)
                bin_valid_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        range_reg    <= range_next;
        cnt_reg      <= cnt_next;
        ptr_reg      <= ptr_next;
        in_total_reg <= in_total_next;
        idx_reg      <= idx_next;
        bin_reg      <= bin_next;
        cval_reg     <= cval_next;
        off_reg      <= off_next;
        ctr_reg      <= ctr_next;
        sh_reg       <= sh_next;
        sp_reg       <= sp_next;
        o_index_reg  <= o_index_next;
        o_center_reg <= o_center_next;
        o_count_reg  <= o_count_next;
        o_share_reg  <= o_share_next;
        o_spread_reg <= o_spread_next;
        o_status_reg <= o_status_next;
        o_last_reg   <= o_last_next;
    end

    // Sample store: one write port for loading, one registered read port for binning.
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_mem[set_total_reg[ADDR_W-1:0]] <= sample;
        store_q_reg <= store_mem[store_ra];
    end

    // Bin counters: read-modify-write during binning, read during output.
    always_ff @(posedge clk)
    begin
        if (bin_we)
            bin_mem[idx_reg] <= bin_wd;
        bin_q_reg  <= bin_mem[bin_ra];
        bin_qv_reg <= bin_valid_reg[bin_ra];
    end

    assign busy       = (state_reg != ST_LOAD);
    assign strobe     = strobe_reg;
    assign bin_index  = o_index_reg;
    assign bin_center = o_center_reg;
    assign raw_count  = o_count_reg;
    assign share      = o_share_reg;
    assign spread     = o_spread_reg;
    assign status     = o_status_reg;
    assign last_bin   = o_last_reg;

endmodule

@@ rtl/hb_checker.sv @@
// Port-level checker for the histogram builder, bound to the top level.
`include "assert_macros.svh"

module hb_checker import hb_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        strobe,
    input logic [5:0]  bin_index,
    input logic [10:0] raw_count,
    input logic [26:0] share,
    input logic [1:0]  status,
    input logic        last_bin
);

    `HB_ASSERT_ALWAYS(a_quiet_in_reset, !rst_n |-> !strobe, "result during reset")
    `HB_ASSERT(a_busy_mid_run, strobe && !last_bin |-> busy, "run ended before last bin")
    `HB_ASSERT(a_status_ends_run, strobe && (status != 2'(STAT_OK)) |-> last_bin && (bin_index == 6'd0) && (raw_count == 11'd0) && (share == 27'd0), "bad status result")
    `HB_ASSERT(a_gap_after_last, strobe && last_bin |=> !strobe, "result after last bin")
    `HB_ASSERT(a_busy_needs_item, $rose(busy) |-> $past(start), "pass began without an item")

endmodule

bind histogram_builder hb_checker u_hb_checker (.*);
